>>> design/vgmce_pkg.sv
package vgmce_pkg;

    localparam int PENDING_BITS_DEF = 20;
    localparam int STEP_W = 4;

    localparam logic [15:0] REG_LOW  = 16'hFF10;
    localparam logic [15:0] REG_HIGH = 16'hFF3F;
    localparam logic [7:0]  CMD_WRITE = 8'hB3;
    localparam logic [7:0]  CMD_END   = 8'h66;
    localparam logic [7:0]  CMD_WAIT_NTSC = 8'h62;
    localparam logic [7:0]  CMD_WAIT_PAL  = 8'h63;
    localparam logic [7:0]  CMD_WAIT_SHORT = 8'h70;
    localparam logic [7:0]  CMD_WAIT_LONG  = 8'h61;
    localparam int WAIT_NTSC  = 735;
    localparam int WAIT_PAL   = 882;
    localparam int WAIT_SHORT_MAX = 16;
    localparam int WAIT_CHUNK = 65535;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_WRITE = 2'd2,
        OP_STOP = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        B_WAIT,
        B_LO,
        B_HI,
        B_B3,
        B_OFS,
        B_DATA,
        B_END
    } bsel_t;

    typedef enum logic [1:0] {
        L_ZERO,
        L_ONE,
        L_TAIL_SHORT,
        L_TAIL_FINAL
    } lsel_t;

    typedef enum logic [1:0] {
        W_HOLD,
        W_SHORT_CLEAR,
        W_CHUNK
    } wupd_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOFLUSH,
        C_WAIT_ZERO,
        C_SHORT,
        C_STOP,
        C_NOREG
    } cond_t;

    typedef struct packed {
        logic  take;
        logic  emit;
        bsel_t bsel;
        lsel_t lsel;
        wupd_t wupd;
        cond_t cond;
        step_t target;
    } ucw_t;

    typedef struct packed {
        logic flush_item;
        logic wait_zero;
        logic wait_short;
        logic is_stop;
        logic no_reg;
        logic out_free;
    } dp_status_t;

    localparam step_t S_IDLE  = 4'd0;
    localparam step_t S_WTEST = 4'd1;
    localparam step_t S_WCMD  = 4'd2;
    localparam step_t S_WLO   = 4'd3;
    localparam step_t S_WHI   = 4'd4;
    localparam step_t S_TAIL  = 4'd5;
    localparam step_t S_RANGE = 4'd6;
    localparam step_t S_B3    = 4'd7;
    localparam step_t S_OFS   = 4'd8;
    localparam step_t S_DATA  = 4'd9;
    localparam step_t S_END   = 4'd10;

    function automatic ucw_t ucode_rom(step_t step);
        ucw_t w;
        w = '{take: 1'b0, emit: 1'b0, bsel: B_WAIT, lsel: L_ZERO, wupd: W_HOLD,
              cond: C_NEXT, target: S_IDLE};
        unique case (step)
            S_IDLE:
            begin
                w.take = 1'b1;
                w.cond = C_NOFLUSH;
                w.target = S_IDLE;
            end
            S_WTEST:
            begin
                w.cond = C_WAIT_ZERO;
                w.target = S_TAIL;
            end
            S_WCMD:
            begin
                w.emit = 1'b1;
                w.bsel = B_WAIT;
                w.lsel = L_TAIL_SHORT;
                w.wupd = W_SHORT_CLEAR;
                w.cond = C_SHORT;
                w.target = S_TAIL;
            end
            S_WLO:
            begin
                w.emit = 1'b1;
                w.bsel = B_LO;
            end
            S_WHI:
            begin
                w.emit = 1'b1;
                w.bsel = B_HI;
                w.lsel = L_TAIL_FINAL;
                w.wupd = W_CHUNK;
                w.cond = C_ALWAYS;
                w.target = S_WTEST;
            end
            S_TAIL:
            begin
                w.cond = C_STOP;
                w.target = S_END;
            end
            S_RANGE:
            begin
                w.cond = C_NOREG;
                w.target = S_IDLE;
            end
            S_B3:
            begin
                w.emit = 1'b1;
                w.bsel = B_B3;
            end
            S_OFS:
            begin
                w.emit = 1'b1;
                w.bsel = B_OFS;
            end
            S_DATA:
            begin
                w.emit = 1'b1;
                w.bsel = B_DATA;
                w.lsel = L_ONE;
                w.cond = C_ALWAYS;
                w.target = S_IDLE;
            end
            S_END:
            begin
                w.emit = 1'b1;
                w.bsel = B_END;
                w.lsel = L_ONE;
                w.cond = C_ALWAYS;
                w.target = S_IDLE;
            end
            default:
            begin
                w.cond = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> design/vgm_command_stream_encoder_core.sv
// An item that causes no bytes (start, advance, or anything while not recording) is taken in
// the idle step alone. A register write runs the wait test, any wait commands (one short byte,
// or a three-byte 0x61 chunk and a new wait test), the tail and range checks, then B3, offset
// and data (an out-of-range address ends at the range check); a stop takes the same wait path
// and then 0x66. Output back-pressure stalls each byte step. Reset (rst_n, asynchronous, active
// low) clears control state but not the data registers; the block is ready right after.
module vgm_command_stream_encoder_core #(
    parameter int PENDING_BITS = vgmce_pkg::PENDING_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] elapsed,
    input  logic [15:0] reg_address,
    input  logic [7:0]  reg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [31:0] elapsed_total,
    output logic [31:0] byte_count
);

    vgmce_pkg::ucw_t       cw;
    vgmce_pkg::dp_status_t status;

    assign in_ready = cw.take;

    vgmce_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cw       (cw)
    );

    vgmce_dp #(
        .PENDING_BITS (PENDING_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cw            (cw),
        .status        (status),
        .in_valid      (in_valid),
        .op            (op),
        .elapsed       (elapsed),
        .reg_address   (reg_address),
        .reg_data      (reg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last          (last),
        .elapsed_total (elapsed_total),
        .byte_count    (byte_count)
    );

endmodule

>>> design/vgmce_seq.sv
module vgmce_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  vgmce_pkg::dp_status_t  status,
    output vgmce_pkg::ucw_t        cw
);

    vgmce_pkg::step_t pc_reg;
    vgmce_pkg::step_t pc_next;
    logic advance;
    logic taken;

    assign cw = vgmce_pkg::ucode_rom(pc_reg);

    // A step that emits a byte holds until the output register can take it.
    assign advance = !cw.emit || status.out_free;

    always_comb
    begin
        unique case (cw.cond)
            vgmce_pkg::C_NEXT:      taken = 1'b0;
            vgmce_pkg::C_ALWAYS:    taken = 1'b1;
            vgmce_pkg::C_NOFLUSH:   taken = !(in_valid && status.flush_item);
            vgmce_pkg::C_WAIT_ZERO: taken = status.wait_zero;
            vgmce_pkg::C_SHORT:     taken = status.wait_short;
            vgmce_pkg::C_STOP:      taken = status.is_stop;
            vgmce_pkg::C_NOREG:     taken = status.no_reg;
            default:                taken = 1'b1;
        endcase
    end

    always_comb
    begin
        if (!advance)
        begin
            pc_next = pc_reg;
        end
        else if (taken)
        begin
            pc_next = cw.target;
        end
        else
        begin
            pc_next = pc_reg + vgmce_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= vgmce_pkg::S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> design/vgmce_dp.sv
module vgmce_dp #(
    parameter int PENDING_BITS = vgmce_pkg::PENDING_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vgmce_pkg::ucw_t       cw,
    output vgmce_pkg::dp_status_t status,
    input  logic                  in_valid,
    input  logic [1:0]            op,
    input  logic [15:0]           elapsed,
    input  logic [15:0]           reg_address,
    input  logic [7:0]            reg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  last,
    output logic [31:0]           elapsed_total,
    output logic [31:0]           byte_count
);

    localparam logic [PENDING_BITS-1:0] PEND_MAX = '1;

    logic                    recording_reg;
    logic [PENDING_BITS-1:0] pending_reg;
    logic [31:0]             sample_total_reg;
    logic [31:0]             emitted_reg;
    logic [1:0]              op_reg;
    logic [15:0]             addr_reg;
    logic [7:0]              data_reg;
    logic                    out_valid_reg;
    logic [7:0]              out_byte_reg;
    logic                    last_reg;
    logic [31:0]             total_reg;
    logic [31:0]             count_reg;

    logic                    accept;
    logic                    fire;
    logic [PENDING_BITS:0]   pend_sum;
    logic                    wait_big;
    logic                    wait_short;
    logic                    tail_none;
    logic                    addr_ok;
    logic [7:0]              wait_code;
    logic [7:0]              byte_next;
    logic                    last_next;
    logic [7:0]              addr_ofs;
    logic [3:0]              pend_minus_one;

    assign accept = in_valid && cw.take;
    assign status.out_free = !out_valid_reg || out_ready;
    assign fire = cw.emit && status.out_free;

    assign pend_sum = {1'b0, pending_reg} + (PENDING_BITS+1)'(elapsed);
    assign wait_big = pending_reg > PENDING_BITS'(vgmce_pkg::WAIT_CHUNK);
    assign wait_short = (pending_reg == PENDING_BITS'(vgmce_pkg::WAIT_NTSC))
                     || (pending_reg == PENDING_BITS'(vgmce_pkg::WAIT_PAL))
                     || (pending_reg <= PENDING_BITS'(vgmce_pkg::WAIT_SHORT_MAX));
    assign addr_ok = (addr_reg >= vgmce_pkg::REG_LOW) && (addr_reg <= vgmce_pkg::REG_HIGH);
    assign addr_ofs = addr_reg[7:0] - vgmce_pkg::REG_LOW[7:0];
    // With no register command to follow, the wait bytes end the item.
    assign tail_none = (op_reg == vgmce_pkg::OP_WRITE) && !addr_ok;
    assign pend_minus_one = pending_reg[3:0] - 4'd1;

    assign status.flush_item = recording_reg && op[1];
    assign status.wait_zero = pending_reg == '0;
    assign status.wait_short = wait_short;
    assign status.is_stop = op_reg == vgmce_pkg::OP_STOP;
    assign status.no_reg = !addr_ok;

    always_comb
    begin
        if (pending_reg == PENDING_BITS'(vgmce_pkg::WAIT_NTSC))
        begin
            wait_code = vgmce_pkg::CMD_WAIT_NTSC;
        end
        else if (pending_reg == PENDING_BITS'(vgmce_pkg::WAIT_PAL))
        begin
            wait_code = vgmce_pkg::CMD_WAIT_PAL;
        end
        else if (wait_short)
        begin
            wait_code = vgmce_pkg::CMD_WAIT_SHORT | {4'd0, pend_minus_one};
        end
        else
        begin
            wait_code = vgmce_pkg::CMD_WAIT_LONG;
        end
    end

    always_comb
    begin
        unique case (cw.bsel)
            vgmce_pkg::B_WAIT: byte_next = wait_code;
            vgmce_pkg::B_LO:   byte_next = wait_big ? 8'hFF : pending_reg[7:0];
            vgmce_pkg::B_HI:   byte_next = wait_big ? 8'hFF : pending_reg[15:8];
            vgmce_pkg::B_B3:   byte_next = vgmce_pkg::CMD_WRITE;
            vgmce_pkg::B_OFS:  byte_next = addr_ofs;
            vgmce_pkg::B_DATA: byte_next = data_reg;
            vgmce_pkg::B_END:  byte_next = vgmce_pkg::CMD_END;
            default:           byte_next = vgmce_pkg::CMD_END;
        endcase
    end

    always_comb
    begin
        unique case (cw.lsel)
            vgmce_pkg::L_ZERO:       last_next = 1'b0;
            vgmce_pkg::L_ONE:        last_next = 1'b1;
            vgmce_pkg::L_TAIL_SHORT: last_next = tail_none && wait_short;
            vgmce_pkg::L_TAIL_FINAL: last_next = tail_none && !wait_big;
            default:                 last_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recording_reg <= 1'b0;
            pending_reg <= '0;
            sample_total_reg <= '0;
            emitted_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (op == vgmce_pkg::OP_START)
                begin
                    if (!recording_reg)
                    begin
                        recording_reg <= 1'b1;
                        pending_reg <= '0;
                        sample_total_reg <= '0;
                        emitted_reg <= '0;
                    end
                end
                else if (op == vgmce_pkg::OP_ADVANCE && recording_reg)
                begin
                    pending_reg <= pend_sum[PENDING_BITS] ? PEND_MAX
                                                          : pend_sum[PENDING_BITS-1:0];
                    sample_total_reg <= sample_total_reg + 32'(elapsed);
                end
            end

            if (fire)
            begin
                emitted_reg <= emitted_reg + 32'd1;
                out_valid_reg <= 1'b1;
                if (cw.bsel == vgmce_pkg::B_END)
                begin
                    recording_reg <= 1'b0;
                end
                unique case (cw.wupd)
                    vgmce_pkg::W_HOLD:
                    begin
                        pending_reg <= pending_reg;
                    end
                    vgmce_pkg::W_SHORT_CLEAR:
                    begin
                        if (wait_short)
                        begin
                            pending_reg <= '0;
                        end
                    end
                    vgmce_pkg::W_CHUNK:
                    begin
                        pending_reg <= wait_big
                            ? pending_reg - PENDING_BITS'(vgmce_pkg::WAIT_CHUNK) : '0;
                    end
                    default:
                    begin
                        pending_reg <= pending_reg;
                    end
                endcase
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op;
            addr_reg <= reg_address;
            data_reg <= reg_data;
        end
        if (fire)
        begin
            out_byte_reg <= byte_next;
            last_reg <= last_next;
            total_reg <= sample_total_reg;
            count_reg <= emitted_reg + 32'd1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte = out_byte_reg;
    assign last = last_reg;
    assign elapsed_total = total_reg;
    assign byte_count = count_reg;

endmodule

>>> test/tb_vgm_command_stream_encoder_core.sv
module tb_vgm_command_stream_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PEND_MAX = (32'd1 << vgmce_pkg::PENDING_BITS_DEF) - 1;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int N_RANDOM = 60;
    localparam int CALM_ITEMS = 15;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_ROWS = 27;

    typedef struct {
        logic [7:0]  code;
        logic        last;
        logic [31:0] total;
        logic [31:0] count;
    } stream_byte_t;

    // nexp of -1 leaves the whole item to the encoder model; otherwise the row
    // lists the bytes it must produce, first byte in the low byte of bytes.
    typedef struct {
        vgmce_pkg::op_t op;
        logic [15:0]    elapsed;
        logic [15:0]    addr;
        logic [7:0]     data;
        int             rep;
        int             nexp;
        logic [31:0]    bytes;
    } stim_row_t;

    stim_row_t stim_rows [N_ROWS] = '{
        '{vgmce_pkg::OP_STOP,    16'd0,     16'h0000, 8'h00, 1,  0,  32'h0},
        '{vgmce_pkg::OP_ADVANCE, 16'd100,   16'h0000, 8'h00, 1,  0,  32'h0},
        '{vgmce_pkg::OP_WRITE,   16'd0,     16'hFF10, 8'h11, 1,  0,  32'h0},
        '{vgmce_pkg::OP_START,   16'd0,     16'h0000, 8'h00, 1,  0,  32'h0},
        '{vgmce_pkg::OP_START,   16'd0,     16'h0000, 8'h00, 1,  0,  32'h0},
        '{vgmce_pkg::OP_WRITE,   16'd0,     16'hFF10, 8'h00, 1,  3,  32'h0000_00B3},
        '{vgmce_pkg::OP_WRITE,   16'd0,     16'hFF3F, 8'hFF, 1,  3,  32'h00FF_2FB3},
        '{vgmce_pkg::OP_WRITE,   16'd0,     16'hFF0F, 8'h12, 1,  0,  32'h0},
        '{vgmce_pkg::OP_WRITE,   16'd0,     16'hFF40, 8'h34, 1,  0,  32'h0},
        '{vgmce_pkg::OP_ADVANCE, 16'd0,     16'h0000, 8'h00, 1,  0,  32'h0},
        '{vgmce_pkg::OP_ADVANCE, 16'd735,   16'h0000, 8'h00, 1,  0,  32'h0},
        '{vgmce_pkg::OP_WRITE,   16'd0,     16'h0000, 8'h5A, 1,  1,  32'h0000_0062},
        '{vgmce_pkg::OP_ADVANCE, 16'd882,   16'h0000, 8'h00, 1,  0,  32'h0},
        '{vgmce_pkg::OP_WRITE,   16'd0,     16'hFF20, 8'hA5, 1,  4,  32'hA510_B363},
        '{vgmce_pkg::OP_ADVANCE, 16'd1,     16'h0000, 8'h00, 1,  0,  32'h0},
        '{vgmce_pkg::OP_STOP,    16'd0,     16'h0000, 8'h00, 1,  2,  32'h0000_6670},
        '{vgmce_pkg::OP_START,   16'd0,     16'h0000, 8'h00, 1,  0,  32'h0},
        '{vgmce_pkg::OP_ADVANCE, 16'd16,    16'h0000, 8'h00, 1,  0,  32'h0},
        '{vgmce_pkg::OP_WRITE,   16'd0,     16'hFFFF, 8'h00, 1,  1,  32'h0000_007F},
        '{vgmce_pkg::OP_ADVANCE, 16'd17,    16'h0000, 8'h00, 1,  0,  32'h0},
        '{vgmce_pkg::OP_WRITE,   16'd0,     16'hFF11, 8'hC3, 1,  -1, 32'h0},
        '{vgmce_pkg::OP_ADVANCE, 16'd65535, 16'h0000, 8'h00, 1,  0,  32'h0},
        '{vgmce_pkg::OP_STOP,    16'd0,     16'h0000, 8'h00, 1,  4,  32'h66FF_FF61},
        '{vgmce_pkg::OP_START,   16'd0,     16'h0000, 8'h00, 1,  0,  32'h0},
        // Enough full-size advances to saturate the pending wait.
        '{vgmce_pkg::OP_ADVANCE, 16'd65535, 16'h0000, 8'h00, 17, 0,  32'h0},
        '{vgmce_pkg::OP_WRITE,   16'd0,     16'hFF25, 8'h3C, 1,  -1, 32'h0},
        '{vgmce_pkg::OP_STOP,    16'd0,     16'h0000, 8'h00, 1,  1,  32'h0000_0066}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [15:0] elapsed;
    logic [15:0] reg_address;
    logic [7:0]  reg_data;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        last;
    logic [31:0] elapsed_total;
    logic [31:0] byte_count;

    // Encoder model state.
    logic        rec_on = 1'b0;
    int unsigned wait_acc = 0;
    logic [31:0] sample_sum = '0;
    logic [31:0] byte_tally = '0;

    stream_byte_t item_bytes[$];
    stream_byte_t expected_bytes[$];
    int          errors = 0;
    int          cycles = 0;
    logic        calm = 1'b0;

    vgm_command_stream_encoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .elapsed       (elapsed),
        .reg_address   (reg_address),
        .reg_data      (reg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last          (last),
        .elapsed_total (elapsed_total),
        .byte_count    (byte_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d bytes outstanding", $time, expected_bytes.size());
            $display("tb_vgm_command_stream_encoder_core: done, errors");
            $finish;
        end
    end

    task automatic put_byte(input logic [7:0] b);
        stream_byte_t sb;
        byte_tally++;
        sb.code = b;
        sb.last = 1'b0;
        sb.total = sample_sum;
        sb.count = byte_tally;
        item_bytes.insert(item_bytes.size(), sb);
    endtask

    task automatic flush_wait;
        int unsigned s;
        s = wait_acc;
        while (s != 0)
        begin
            if (s == vgmce_pkg::WAIT_NTSC)
            begin
                put_byte(vgmce_pkg::CMD_WAIT_NTSC);
                s = 0;
            end
            else if (s == vgmce_pkg::WAIT_PAL)
            begin
                put_byte(vgmce_pkg::CMD_WAIT_PAL);
                s = 0;
            end
            else if (s <= vgmce_pkg::WAIT_SHORT_MAX)
            begin
                put_byte(vgmce_pkg::CMD_WAIT_SHORT + 8'(s - 1));
                s = 0;
            end
            else if (s <= vgmce_pkg::WAIT_CHUNK)
            begin
                put_byte(vgmce_pkg::CMD_WAIT_LONG);
                put_byte(s[7:0]);
                put_byte(s[15:8]);
                s = 0;
            end
            else
            begin
                put_byte(vgmce_pkg::CMD_WAIT_LONG);
                put_byte(8'hFF);
                put_byte(8'hFF);
                s -= vgmce_pkg::WAIT_CHUNK;
            end
        end
        wait_acc = 0;
    endtask

    task automatic encode_item(input vgmce_pkg::op_t o, input logic [15:0] e,
                               input logic [15:0] a, input logic [7:0] d);
        int unsigned acc;
        item_bytes.delete();
        if (o == vgmce_pkg::OP_START)
        begin
            if (!rec_on)
            begin
                rec_on = 1'b1;
                wait_acc = 0;
                sample_sum = '0;
                byte_tally = '0;
            end
        end
        else if (rec_on)
        begin
            if (o == vgmce_pkg::OP_ADVANCE)
            begin
                acc = wait_acc + 32'(e);
                wait_acc = (acc > PEND_MAX) ? PEND_MAX : acc;
                sample_sum = sample_sum + 32'(e);
            end
            else
            begin
                flush_wait();
                if (o == vgmce_pkg::OP_WRITE)
                begin
                    if (a >= vgmce_pkg::REG_LOW && a <= vgmce_pkg::REG_HIGH)
                    begin
                        put_byte(vgmce_pkg::CMD_WRITE);
                        put_byte(8'(a - vgmce_pkg::REG_LOW));
                        put_byte(d);
                    end
                end
                else
                begin
                    put_byte(vgmce_pkg::CMD_END);
                    rec_on = 1'b0;
                end
                if (item_bytes.size() > 0)
                    item_bytes[item_bytes.size() - 1].last = 1'b1;
            end
        end
    endtask

    task automatic send_item(input vgmce_pkg::op_t o, input logic [15:0] e,
                             input logic [15:0] a, input logic [7:0] d, input int nexp,
                             input logic [31:0] listed);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        elapsed <= e;
        reg_address <= a;
        reg_data <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        encode_item(o, e, a, d);
        if (nexp >= 0)
        begin
            if (item_bytes.size() != nexp)
            begin
                $display("%0t: %s item: expected %0d bytes, actual %0d", $time, o.name(),
                         nexp, item_bytes.size());
                errors++;
            end
            foreach (item_bytes[k])
                if (k < 4)
                    item_bytes[k].code = listed[8*k +: 8];
        end
        foreach (item_bytes[k])
            expected_bytes.insert(expected_bytes.size(), item_bytes[k]);
    endtask

    always @(posedge clk)
    begin : check_out
        stream_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, actual %02h", $time, out_byte);
                errors++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.code)
                begin
                    $display("%0t: out_byte expected %02h, actual %02h", $time, want.code,
                             out_byte);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %0b, actual %0b", $time, want.last, last);
                    errors++;
                end
                if (elapsed_total !== want.total)
                begin
                    $display("%0t: elapsed_total expected %0d, actual %0d", $time, want.total,
                             elapsed_total);
                    errors++;
                end
                if (byte_count !== want.count)
                begin
                    $display("%0t: byte_count expected %0d, actual %0d", $time, want.count,
                             byte_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin : receiver
        int gap;
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 16);
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : sender
        int n_eff;
        int pick;
        logic paused;
        vgmce_pkg::op_t o;
        logic [15:0] e;
        logic [15:0] a;
        logic [7:0] d;

        rst_n = 1'b0;
        in_valid = 1'b0;
        op = vgmce_pkg::OP_START;
        elapsed = '0;
        reg_address = '0;
        reg_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_rows[r])
            for (int k = 0; k < stim_rows[r].rep; k++)
                send_item(stim_rows[r].op, stim_rows[r].elapsed, stim_rows[r].addr,
                          stim_rows[r].data, stim_rows[r].nexp, stim_rows[r].bytes);

        // Mostly well-formed sessions: start, a mix of waits and writes, the odd stop.
        // Items the encoder ignores are not counted.
        n_eff = 0;
        paused = 1'b0;
        while (n_eff < N_RANDOM)
        begin
            if (!paused && n_eff >= N_RANDOM / 2)
            begin
                paused = 1'b1;
                @(negedge clk);
                in_valid <= 1'b0;
                while (expected_bytes.size() != 0)
                    @(negedge clk);
            end
            if (n_eff >= N_RANDOM - CALM_ITEMS)
                calm = 1'b1;
            e = 16'($urandom);
            a = 16'($urandom);
            d = 8'($urandom);
            pick = $urandom_range(0, 99);
            if (!rec_on)
            begin
                o = (pick < 75) ? vgmce_pkg::OP_START
                                : vgmce_pkg::op_t'($urandom_range(1, 3));
            end
            else
            begin
                if (pick < 45)
                    o = vgmce_pkg::OP_ADVANCE;
                else if (pick < 82)
                    o = vgmce_pkg::OP_WRITE;
                else if (pick < 92)
                    o = vgmce_pkg::OP_STOP;
                else
                    o = vgmce_pkg::OP_START;
                pick = $urandom_range(0, 99);
                if (o == vgmce_pkg::OP_ADVANCE)
                begin
                    if (pick < 5)
                        e = '0;
                    else if (pick < 30)
                        e = 16'($urandom_range(1, vgmce_pkg::WAIT_SHORT_MAX));
                    else if (pick < 38)
                        e = 16'(vgmce_pkg::WAIT_NTSC);
                    else if (pick < 45)
                        e = 16'(vgmce_pkg::WAIT_PAL);
                    else if (pick < 75)
                        e = 16'($urandom_range(17, 2000));
                    else if (pick >= 88)
                        e = 16'hFFFF;
                end
                else if (o == vgmce_pkg::OP_WRITE)
                begin
                    if (pick < 70)
                        a = vgmce_pkg::REG_LOW + 16'($urandom_range(0, 47));
                    else if (pick < 75)
                        a = vgmce_pkg::REG_LOW - 16'd1;
                    else if (pick < 80)
                        a = vgmce_pkg::REG_HIGH + 16'd1;
                end
            end
            if (rec_on ? (o != vgmce_pkg::OP_START) : (o == vgmce_pkg::OP_START))
                n_eff++;
            send_item(o, e, a, d, -1, '0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (errors == 0)
            $display("tb_vgm_command_stream_encoder_core: done, clean");
        else
            $display("tb_vgm_command_stream_encoder_core: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
design/vgmce_pkg.sv
design/vgmce_seq.sv
design/vgmce_dp.sv
design/vgm_command_stream_encoder_core.sv
test/tb_vgm_command_stream_encoder_core.sv
